// ----- src/assert_macros.svh -----
// Concurrent assertion helpers, clocked on the rising edge and held off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define EPL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

`define EPL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

`endif

// ----- src/epl_pkg.sv -----
package epl_pkg;

    localparam int PIPE_DEPTH = 11;

    localparam logic signed [16:0] OFFSET_RESET = 17'sd18000;
    localparam logic REG_IDX_OFFSET = 1'b0;

    localparam logic signed [34:0] LOCAL_BASE = 35'sd946684800;
    localparam logic signed [34:0] LOCAL_END  = 35'sd4102444800;

    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [30:0] RECIP_675    = 31'd1628906115;
    localparam int          RECIP_675_SH = 40;

    localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;
    localparam logic [15:0] RECIP_1461     = 16'd45934;
    localparam int          RECIP_1461_SH  = 26;

    localparam logic [8:0] DAYS_PER_YEAR_MONTHS = 9'd372;
    localparam logic [4:0] DAYS_PER_MONTH_SLOT  = 5'd31;

    localparam logic [32:0] MAX_PACKED = 33'd3214079999;

    function automatic logic [10:0] year_start(input logic [1:0] yic);
        logic [10:0] s;
        case (yic)
            2'd0:    s = 11'd0;
            2'd1:    s = 11'd366;
            2'd2:    s = 11'd731;
            default: s = 11'd1096;
        endcase
        return s;
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] s;
        case (m)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd59;
            4'd3:    s = 9'd90;
            4'd4:    s = 9'd120;
            4'd5:    s = 9'd151;
            4'd6:    s = 9'd181;
            4'd7:    s = 9'd212;
            4'd8:    s = 9'd243;
            4'd9:    s = 9'd273;
            4'd10:   s = 9'd304;
            4'd11:   s = 9'd334;
            default: s = 9'd0;
        endcase
        if (leap && (m >= 4'd2))
        begin
            s = s + 9'd1;
        end
        return s;
    endfunction

endpackage

// ----- src/epoch_to_packed_local_time.sv -----
// Unix UTC second count to packed local date and time.
// Input channel: drive utc_seconds with start high; a beat is taken on every
// rising edge where start is high and busy is low. busy never rises, so one
// beat can enter in every cycle.
// Result channel: done pulses for one cycle with packed_time and ok.
// Throughput is one beat per cycle, set by an 11-stage pipeline whose
// longest steps are the reciprocal multiplies for the day split.
// ok is high when the local year is 2000..2099; otherwise packed_time is 0.
// The receiver cannot stall: every result is shown for exactly one cycle.
// Configuration: APB register 0 (byte address 0) holds utc_offset_seconds,
// 17-bit signed, added to every beat. Write it only while the pipeline is
// empty. pready is tied high.
// Reset (rst_n low) clears the pipeline valids and loads the offset with
// 18000 seconds; beats in flight are dropped.
module epoch_to_packed_local_time
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [32:0] utc_seconds,
    output logic        done,
    output logic [31:0] packed_time,
    output logic        ok,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic signed [16:0] offset_reg;
    logic [epl_pkg::PIPE_DEPTH-1:0] vld_reg, vld_next;
    logic accept;
    logic cfg_wr;

    logic signed [34:0] local1_reg, local1_next;
    logic        ok2_reg, ok3_reg, ok4_reg, ok5_reg, ok6_reg, ok7_reg, ok8_reg, ok9_reg;
    logic        ok10_reg;
    logic [31:0] t2_reg, t3_reg, t4_reg;
    logic [55:0] prod3_reg;
    logic [15:0] q4_reg;
    logic [31:0] qp4_reg;
    logic [15:0] days5_reg, days6_reg;
    logic [16:0] sod5_reg, sod6_reg, sod7_reg, sod8_reg, sod9_reg, sod10_reg;
    logic [31:0] prod6_reg;
    logic [4:0]  cyc7_reg;
    logic [10:0] doc7_reg;
    logic [6:0]  year8_reg, year9_reg;
    logic [8:0]  doy8_reg;
    logic        leap8_reg;
    logic [3:0]  month9_reg;
    logic [4:0]  day9_reg;
    logic [15:0] ym10_reg;
    logic [31:0] packed_reg;
    logic        ok_reg;

    logic signed [34:0] rel2;
    logic        ok2_next;
    logic [55:0] prod3_next;
    logic [15:0] q4_next;
    logic [32:0] qp4_full;
    logic [31:0] r5_full;
    logic [17:0] r5;
    logic [15:0] days5_next;
    logic [16:0] sod5_next;
    logic [31:0] prod6_next;
    logic [4:0]  cyc7_next;
    logic [15:0] cyc_days;
    logic [1:0]  yic8;
    logic [10:0] doy8_full;
    logic [3:0]  month9_next;
    logic [8:0]  day9_full;
    logic [15:0] ym10_next;
    logic [31:0] packed_next;

    assign accept = start && !busy;
    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == epl_pkg::REG_IDX_OFFSET);
    assign prdata = (paddr[2] == epl_pkg::REG_IDX_OFFSET) ?
                    {{15{offset_reg[16]}}, offset_reg} : 32'd0;

    assign vld_next = {vld_reg[epl_pkg::PIPE_DEPTH-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            offset_reg <= epl_pkg::OFFSET_RESET;
            ok_reg     <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            ok_reg  <= vld_reg[epl_pkg::PIPE_DEPTH-2] && ok10_reg;
            if (cfg_wr)
            begin
                offset_reg <= pwdata[16:0];
            end
        end
    end

    // Stage 1: apply zone offset
    assign local1_next = $signed({2'b00, utc_seconds}) + $signed({{18{offset_reg[16]}}, offset_reg});

    // Stage 2: range check, rebase to 2000-01-01
    assign ok2_next = (local1_reg >= epl_pkg::LOCAL_BASE) && (local1_reg < epl_pkg::LOCAL_END);
    assign rel2     = local1_reg - epl_pkg::LOCAL_BASE;

    // Stage 3: estimate days by reciprocal of 675 on seconds over 128
    assign prod3_next = 56'(t2_reg[31:7]) * 56'(epl_pkg::RECIP_675);

    // Stage 4: back-multiply estimate
    assign q4_next  = prod3_reg[epl_pkg::RECIP_675_SH+15:epl_pkg::RECIP_675_SH];
    assign qp4_full = 33'(q4_next) * 33'(epl_pkg::SECS_PER_DAY);

    // Stage 5: correct estimate by one
    assign r5_full = t4_reg - qp4_reg;
    assign r5      = r5_full[17:0];
    always_comb
    begin
        if (r5 >= 18'(epl_pkg::SECS_PER_DAY))
        begin
            days5_next = q4_reg + 16'd1;
            sod5_next  = 17'(r5 - 18'(epl_pkg::SECS_PER_DAY));
        end
        else
        begin
            days5_next = q4_reg;
            sod5_next  = r5[16:0];
        end
    end

    // Stage 6: split days into four-year cycles
    assign prod6_next = 32'(days5_reg) * 32'(epl_pkg::RECIP_1461);

    // Stage 7: day of cycle
    assign cyc7_next = prod6_reg[epl_pkg::RECIP_1461_SH+4:epl_pkg::RECIP_1461_SH];
    assign cyc_days  = 16'(cyc7_next) * 16'(epl_pkg::DAYS_PER_CYCLE);

    // Stage 8: year within cycle, first year of each cycle is leap
    always_comb
    begin
        if (doc7_reg >= epl_pkg::year_start(2'd3))
        begin
            yic8 = 2'd3;
        end
        else if (doc7_reg >= epl_pkg::year_start(2'd2))
        begin
            yic8 = 2'd2;
        end
        else if (doc7_reg >= epl_pkg::year_start(2'd1))
        begin
            yic8 = 2'd1;
        end
        else
        begin
            yic8 = 2'd0;
        end
    end
    assign doy8_full = doc7_reg - epl_pkg::year_start(yic8);

    // Stage 9: month and day of month
    always_comb
    begin
        month9_next = 4'd0;
        for (int m = 1; m < 12; m++)
        begin
            if (doy8_reg >= epl_pkg::month_start(4'(m), leap8_reg))
            begin
                month9_next = month9_next + 4'd1;
            end
        end
    end
    assign day9_full = doy8_reg - epl_pkg::month_start(month9_next, leap8_reg);

    // Stage 10: fold year, month, day
    assign ym10_next = 16'(year9_reg) * 16'(epl_pkg::DAYS_PER_YEAR_MONTHS)
                     + 16'(month9_reg) * 16'(epl_pkg::DAYS_PER_MONTH_SLOT)
                     + 16'(day9_reg);

    // Stage 11: scale to seconds, drop out-of-range beats
    assign packed_next = ok10_reg ?
                         (32'(ym10_reg) * 32'(epl_pkg::SECS_PER_DAY) + 32'(sod10_reg)) : 32'd0;

    always_ff @(posedge clk)
    begin
        local1_reg <= local1_next;

        ok2_reg <= ok2_next;
        t2_reg  <= rel2[31:0];

        ok3_reg   <= ok2_reg;
        t3_reg    <= t2_reg;
        prod3_reg <= prod3_next;

        ok4_reg <= ok3_reg;
        t4_reg  <= t3_reg;
        q4_reg  <= q4_next;
        qp4_reg <= qp4_full[31:0];

        ok5_reg   <= ok4_reg;
        days5_reg <= days5_next;
        sod5_reg  <= sod5_next;

        ok6_reg   <= ok5_reg;
        days6_reg <= days5_reg;
        sod6_reg  <= sod5_reg;
        prod6_reg <= prod6_next;

        ok7_reg  <= ok6_reg;
        sod7_reg <= sod6_reg;
        cyc7_reg <= cyc7_next;
        doc7_reg <= 11'(days6_reg - cyc_days);

        ok8_reg   <= ok7_reg;
        sod8_reg  <= sod7_reg;
        year8_reg <= {cyc7_reg, yic8};
        doy8_reg  <= doy8_full[8:0];
        leap8_reg <= (yic8 == 2'd0);

        ok9_reg    <= ok8_reg;
        sod9_reg   <= sod8_reg;
        year9_reg  <= year8_reg;
        month9_reg <= month9_next;
        day9_reg   <= day9_full[4:0];

        ok10_reg  <= ok9_reg;
        sod10_reg <= sod9_reg;
        ym10_reg  <= ym10_next;

        packed_reg <= packed_next;
    end

    assign done        = vld_reg[epl_pkg::PIPE_DEPTH-1];
    assign packed_time = packed_reg;
    assign ok          = ok_reg;

endmodule

// ----- src/epl_checker.sv -----
`include "assert_macros.svh"

module epl_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] packed_time,
    input logic        ok
);

    `EPL_ASSERT_IMP(a_done_latency, clk, rst_n, done, $past(start && !busy, epl_pkg::PIPE_DEPTH))
    `EPL_ASSERT_IMP(a_ok_with_done, clk, rst_n, ok, done)
    `EPL_ASSERT_IMP(a_zero_when_bad, clk, rst_n, done && !ok, packed_time == 32'd0)
    `EPL_ASSERT_IMP(a_packed_max, clk, rst_n, done && ok, {1'b0, packed_time} <= epl_pkg::MAX_PACKED)

endmodule

bind epoch_to_packed_local_time epl_checker u_epl_checker (.*);
